// File: sv/grid_path_counter_top_assert.svh
// Assertion macros for the file that checks the grid path counter (grid_path_counter_top.sv).
`ifndef GRID_PATH_COUNTER_TOP_ASSERT_SVH
`define GRID_PATH_COUNTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid path counter check failed");

// The consequent must hold in the cycle after the antecedent.
`define GPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid path counter check failed");

`endif

// File: sv/gpc_pkg.sv
package gpc_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int COL_BITS    = $clog2(MAX_COLUMNS);
	localparam int COUNT_BITS  = 32;
	localparam int OUT_BITS    = 32;
	localparam int ROW_BITS    = 16;
	localparam int CFG_BITS    = 16;
	localparam int CFG_IDX_BITS = 3;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [COL_BITS-1:0]   col_t;
	typedef logic [ROW_BITS-1:0]   row_t;

	localparam count_t COUNT_MAX = '1;
	localparam logic [63:0] OUT_MAX = 64'((65'd1 << OUT_BITS) - 65'd1);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ROW_COUNT    = 3'd0,
		REG_COLUMN_COUNT = 3'd1,
		REG_START_ROW    = 3'd2,
		REG_START_COLUMN = 3'd3,
		REG_END_ROW      = 3'd4,
		REG_END_COLUMN   = 3'd5
	} cfg_reg_e;

	// Per-cell decisions made at acceptance and carried to the update stage.
	typedef struct packed {
		col_t column;
		logic in_rect;
		logic is_start;
		logic use_up;
		logic use_left;
		logic is_end;
		logic last_grid;
	} cell_info_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic stall;
	} upd_status_t;

endpackage

// File: sv/gpc_ram.sv
module gpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/gpc_scan.sv
module gpc_scan
	import gpc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    accept,
	input  logic                    cell_open,
	output cell_info_t              info
);

	row_t             row_count_q, start_row_q, end_row_q, row_q;
	logic [COL_BITS:0] column_count_q;
	col_t             start_column_q, end_column_q, col_q;
	logic [COL_BITS:0] cols_eff;
	row_t             rows_eff;
	logic             last_col, last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= row_t'(1);
			column_count_q <= (COL_BITS+1)'(1);
			start_row_q    <= '0;
			start_column_q <= '0;
			end_row_q      <= '0;
			end_column_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				REG_ROW_COUNT:    row_count_q    <= cfg_data[ROW_BITS-1:0];
				REG_COLUMN_COUNT: column_count_q <= cfg_data[COL_BITS:0];
				REG_START_ROW:    start_row_q    <= cfg_data[ROW_BITS-1:0];
				REG_START_COLUMN: start_column_q <= cfg_data[COL_BITS-1:0];
				REG_END_ROW:      end_row_q      <= cfg_data[ROW_BITS-1:0];
				REG_END_COLUMN:   end_column_q   <= cfg_data[COL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (column_count_q == '0) begin
			cols_eff = (COL_BITS+1)'(1);
		end else if (column_count_q > (COL_BITS+1)'(MAX_COLUMNS)) begin
			cols_eff = (COL_BITS+1)'(MAX_COLUMNS);
		end else begin
			cols_eff = column_count_q;
		end
		rows_eff = (row_count_q == '0) ? row_t'(1) : row_count_q;
		last_col = {1'b0, col_q} >= cols_eff - (COL_BITS+1)'(1);
		last_row = row_q >= rows_eff - row_t'(1);

		info.column    = col_q;
		info.in_rect   = cell_open && row_q >= start_row_q && row_q <= end_row_q
			&& col_q >= start_column_q && col_q <= end_column_q;
		info.is_start  = row_q == start_row_q && col_q == start_column_q;
		info.use_up    = row_q > start_row_q;
		info.use_left  = col_q > start_column_q;
		info.is_end    = row_q == end_row_q && col_q == end_column_q;
		info.last_grid = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col && last_row) begin
				row_q <= '0;
				col_q <= '0;
			end else if (last_col) begin
				row_q <= row_q + row_t'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + col_t'(1);
			end
		end
	end

endmodule

// File: sv/gpc_update.sv
module gpc_update
	import gpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  cell_info_t          info,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [OUT_BITS-1:0] out_count,
	output logic                out_saturated,
	output upd_status_t         status
);

	logic       valid_s1, fwd_s1;
	cell_info_t info_s1;
	count_t     fwd_val_s1;
	count_t     rdata, up, add_a, add_b, sum_clip, count, left_q, answer_q, final_ans;
	logic [COUNT_BITS:0] sum;
	logic [63:0] wide_ans;
	logic       stall, advance, out_valid_q, clip;

	assign stall   = valid_s1 && info_s1.last_grid && out_valid_q && !out_ready;
	assign advance = valid_s1 && !stall;

	gpc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (MAX_COLUMNS)
	) u_row_store (
		.clk   (clk),
		.we    (advance),
		.waddr (info_s1.column),
		.wdata (count),
		.re    (accept),
		.raddr (info.column),
		.rdata (rdata)
	);

	always_comb begin
		up    = fwd_s1 ? fwd_val_s1 : rdata;
		add_a = info_s1.use_up ? up : '0;
		add_b = info_s1.use_left ? left_q : '0;
		sum   = {1'b0, add_a} + {1'b0, add_b};
		sum_clip = (sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
		if (!info_s1.in_rect) begin
			count = '0;
		end else if (info_s1.is_start) begin
			count = count_t'(1);
		end else begin
			count = sum_clip;
		end
		final_ans = info_s1.is_end ? count : answer_q;
		wide_ans  = 64'(final_ans);
		clip      = wide_ans > OUT_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || stall;
		end
	end

	// A cell whose column was written by the departing cell in the same
	// cycle would read stale data, so that write is forwarded.
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1    <= info;
			fwd_s1     <= advance && info_s1.column == info.column;
			fwd_val_s1 <= count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			answer_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				left_q <= count;
				if (info_s1.last_grid) begin
					answer_q <= '0;
				end else if (info_s1.is_end) begin
					answer_q <= count;
				end
			end
			if (advance && info_s1.last_grid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && info_s1.last_grid) begin
			out_count     <= clip ? OUT_MAX[OUT_BITS-1:0] : wide_ans[OUT_BITS-1:0];
			out_saturated <= clip || final_ans == COUNT_MAX;
		end
	end

	assign out_valid    = out_valid_q;
	assign status.valid = valid_s1;
	assign status.last  = info_s1.last_grid;
	assign status.stall = stall;

endmodule

// File: sv/grid_path_counter_top.sv
// Grid path counter. Grid cells stream in row-major order, one cell per transfer, with
// the open flag in bit 0 of s_axis_tdata; after the last cell of a grid (row_count rows of
// column_count cells) one result transfer gives the number of right/down paths from the
// start cell to the end cell, saturated, with the saturation flag in m_axis_tuser. The
// block takes one cell every cycle while not stalled; the result is registered as the last
// cell leaves the update stage, and the next grid can follow at once. The figure is set by
// the row store: each cell does one read and one write of it, in two stages, with the
// write forwarded to a cell of the same column that enters in the same cycle (one-column
// grids). Input stalls only when a finished result still waits in the output register and
// another grid ends. Configuration must be written via cfg_we, cfg_index and cfg_data
// while no grid is in progress (unenforced); the row store needs no clearing after reset.
module grid_path_counter_top
	import gpc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [7:0]              s_axis_tdata,  // [0] cell_open, [7:1] zero
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [31:0]             m_axis_tdata,  // [31:0] path_count
	output logic                    m_axis_tuser   // [0] saturated
);

	`include "grid_path_counter_top_assert.svh"

	logic        accept;
	cell_info_t  info;
	upd_status_t status;

	// A cell is taken whenever the update stage is not held by a full output register.
	assign s_axis_tready = !status.stall;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Position tracking and configuration registers; decides what each cell contributes.
	gpc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.cell_open (s_axis_tdata[0]),
		.info      (info)
	);

	// Row store read-modify-write, saturating sum and result register.
	gpc_update u_update (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.info          (info),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_count     (m_axis_tdata),
		.out_saturated (m_axis_tuser),
		.status        (status)
	);

	// Input is refused only while a grid-ending cell waits behind an untaken result.
	`GPC_ASSERT_NOW(a_stall_cause, !s_axis_tready,
		status.valid && status.last && m_axis_tvalid && !m_axis_tready)
	// The last cell of a grid reaches the update stage in the following cycle.
	`GPC_ASSERT_NEXT(a_last_enters, accept && info.last_grid, status.valid && status.last)
	// After a grid ends the position starts over at the first column.
	`GPC_ASSERT_NEXT(a_grid_restart, accept && info.last_grid, info.column == '0)

endmodule
